// ===== hdl/ovnh_pkg.sv =====
package ovnh_pkg;

	// Seed grid geometry. The grid is square and a power of two wide.
	localparam int GRID_LOG2  = 8;
	localparam int GRID_WIDTH = 1 << GRID_LOG2;
	localparam int GRID_DEPTH = GRID_WIDTH * GRID_WIDTH;
	localparam int ADDR_W     = 2 * GRID_LOG2;

	// Field widths on the ports.
	localparam int SEED_W    = 16;
	localparam int INDEX_W   = 16;
	localparam int POINT_W   = 8;
	localparam int HEIGHT_W  = 8;
	localparam int KCNT_W    = 4;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 24;

	// Octave index and datapath widths.
	localparam int OCT_W  = $clog2(GRID_LOG2);
	localparam int WGT_W  = 2 * GRID_LOG2 + 1;
	localparam int NUM_W  = 2 * GRID_LOG2 + SEED_W;
	localparam int ACC_W  = SEED_W + GRID_LOG2;
	localparam int DIV_W  = GRID_LOG2;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT   = 2'd2;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		cmd_t                 cmd;
		logic [ADDR_W-1:0]    addr;
		logic [SEED_W-1:0]    value;
		logic [GRID_LOG2-1:0] col;
		logic [GRID_LOG2-1:0] row;
	} job_t;

	typedef struct packed {
		logic [KCNT_W-1:0]   octaves;
		logic [HEIGHT_W-1:0] min_height;
		logic [HEIGHT_W-1:0] max_height;
	} cfg_t;

endpackage

// ===== hdl/octave_value_noise_height.sv =====
// Channel  Dir  Accepted when           Payload
// s        in   s_tvalid && s_tready    tuser: cmd; tdata: index, value, x, y
// m        out  m_tvalid && m_tready    tdata: noise_value, height
// cfg      in   cfg_we                  cfg_index selects, cfg_data carries
//
// A seed write is done in the back end as it leaves the queue; a query reads
// four corners for each of its K octaves, where K is the effective octave count,
// one corner read per cycle through the single grid memory port, then passes the
// read pipeline, normalization and the result load before its result is offered;
// the next item can leave the queue in the cycle in which that result is offered.
// A two-entry queue parts the input from the back end, and the result register
// lets the back end go on with seed writes while a result waits.
// Reset clears control state and the configuration; the seed grid is not cleared.
module octave_value_noise_height (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [15:0] seed_index, [31:16] seed_value, [39:32] point_x, [47:40] point_y
	input  logic [ovnh_pkg::S_TDATA_W-1:0]   s_tdata,
	// [0] cmd
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [15:0] noise_value, [23:16] height
	output logic [ovnh_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [ovnh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ovnh_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ovnh_pkg::*;

	cfg_t cfg_q;
	logic job_valid;
	job_t job;
	logic job_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octaves    <= KCNT_W'(1);
			cfg_q.min_height <= '0;
			cfg_q.max_height <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OCTAVE_COUNT: cfg_q.octaves    <= cfg_data[KCNT_W-1:0];
				CFG_MIN_HEIGHT:   cfg_q.min_height <= cfg_data[HEIGHT_W-1:0];
				CFG_MAX_HEIGHT:   cfg_q.max_height <= cfg_data[HEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ovnh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	ovnh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.cfg       (cfg_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== hdl/ovnh_front.sv =====
module ovnh_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ovnh_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                            s_tuser,
	output logic                            job_valid,
	output ovnh_pkg::job_t                  job,
	input  logic                            job_pop
);
	import ovnh_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [INDEX_W-1:0] seed_index;
	logic [SEED_W-1:0]  seed_value;
	logic [POINT_W-1:0] point_x;
	logic [POINT_W-1:0] point_y;
	logic               index_ok;
	logic               keep;
	logic               push;
	job_t               job_in;

	job_t               slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign seed_index = s_tdata[15:0];
	assign seed_value = s_tdata[31:16];
	assign point_x    = s_tdata[39:32];
	assign point_y    = s_tdata[47:40];

	// A write outside the grid has no effect, so it is dropped here.
	assign index_ok = ((32'(seed_index) >> ADDR_W) == 32'd0);

	always_comb begin
		job_in.cmd   = cmd_t'(s_tuser);
		job_in.addr  = ADDR_W'(seed_index);
		job_in.value = seed_value;
		job_in.col   = GRID_LOG2'(point_x);
		job_in.row   = GRID_LOG2'(point_y);
	end

	assign keep     = (job_in.cmd == CMD_QUERY) || index_ok;
	assign s_tready = (cnt_q != CNT_W'(DEPTH));
	assign push     = s_tvalid && s_tready && keep;

	assign job_valid = (cnt_q != '0);
	assign job       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (job_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !job_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && job_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= job_in;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(DEPTH)) && !(job_pop && cnt_q == '0))
		else $error("item queue count out of range");

endmodule

// ===== hdl/ovnh_back.sv =====
module ovnh_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	input  ovnh_pkg::job_t                  job,
	output logic                            job_pop,
	input  ovnh_pkg::cfg_t                  cfg,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ovnh_pkg::M_TDATA_W-1:0]  m_tdata
);
	import ovnh_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	localparam int DIV_STEP = 4;
	localparam int DIV_CYC  = SEED_W / DIV_STEP;
	localparam int DC_W     = $clog2(DIV_CYC);
	localparam logic [DC_W-1:0] DIV_LAST = DC_W'(DIV_CYC - 1);
	localparam logic [GRID_LOG2:0] PITCH0 = (GRID_LOG2 + 1)'(GRID_WIDTH);
	localparam int T_W = SEED_W + HEIGHT_W + 2;

	logic [1:0]            state_q;
	logic [KCNT_W-1:0]     k_q;
	logic [GRID_LOG2-1:0]  col_q;
	logic [GRID_LOG2-1:0]  row_q;
	logic [OCT_W+1:0]      iss_q;
	logic                  iss_on_q;

	logic                  v_s1;
	logic [OCT_W-1:0]      oct_s1;
	logic                  last_s1;
	logic [WGT_W-1:0]      w_s1;
	logic [SEED_W-1:0]     rdata_s1;

	logic                  v_s2;
	logic [OCT_W-1:0]      oct_s2;
	logic                  last_s2;
	logic [NUM_W-1:0]      prod_s2;

	logic [NUM_W-1:0]      num_q;
	logic [ACC_W-1:0]      acc_q;
	logic [DIV_W-1:0]      rem_q;
	logic [SEED_W-1:0]     quo_q;
	logic [DC_W-1:0]       div_cnt_q;
	logic                  m_valid_q;
	logic [SEED_W-1:0]     noise_q;
	logic [HEIGHT_W-1:0]   height_q;

	logic [SEED_W-1:0]     grid_mem [GRID_DEPTH];

	logic                  start;
	logic                  mem_we;
	logic [KCNT_W-1:0]     k_eff;
	logic [OCT_W-1:0]      k_last;
	logic                  issue;
	logic [OCT_W-1:0]      oct_i;
	logic [1:0]            corner;
	logic                  last_iss;
	logic [GRID_LOG2:0]    pitch;
	logic [GRID_LOG2-1:0]  mask;
	logic [GRID_LOG2-1:0]  bx;
	logic [GRID_LOG2-1:0]  by;
	logic [GRID_LOG2-1:0]  x1;
	logic [GRID_LOG2-1:0]  y1;
	logic [GRID_LOG2-1:0]  x2;
	logic [GRID_LOG2-1:0]  y2;
	logic [GRID_LOG2:0]    wx;
	logic [GRID_LOG2:0]    wy;
	logic [2*GRID_LOG2+1:0] wprod;
	logic [ADDR_W-1:0]     rd_addr;
	logic [SEED_W+WGT_W-1:0] prod_full;

	logic [NUM_W-1:0]      num_sum;
	logic [OCT_W:0]        oct_rem;
	logic [OCT_W+1:0]      shamt;
	logic [NUM_W-1:0]      num_shift;
	logic [OCT_W-1:0]      wsh;
	logic [ACC_W-1:0]      acc_add;
	logic [ACC_W-1:0]      acc_next;
	logic                  fold_last;

	logic [DIV_W:0]        pow_k;
	logic [DIV_W-1:0]      divisor;
	logic [DIV_W-1:0]      rem_d;
	logic [SEED_W-1:0]     quo_d;

	logic signed [HEIGHT_W:0] hdiff;
	logic signed [T_W-1:0]    hprod;
	logic signed [T_W-1:0]    hsum;
	logic                     out_load;

	// Front queue handshake and item dispatch.
	assign job_pop = (state_q == ST_IDLE) && job_valid;
	assign start   = job_pop && (job.cmd == CMD_QUERY);
	assign mem_we  = job_pop && (job.cmd == CMD_WRITE);

	always_comb begin
		priority if (cfg.octaves == '0) begin
			k_eff = KCNT_W'(1);
		end else if (cfg.octaves > KCNT_W'(GRID_LOG2)) begin
			k_eff = KCNT_W'(GRID_LOG2);
		end else begin
			k_eff = cfg.octaves;
		end
	end

	assign k_last = OCT_W'(k_q - KCNT_W'(1));

	// Corner issue: one seed read per cycle, octave in the upper bits of the counter.
	assign issue    = (state_q == ST_RUN) && iss_on_q;
	assign oct_i    = iss_q[OCT_W+1:2];
	assign corner   = iss_q[1:0];
	assign last_iss = (oct_i == k_last) && (&corner);

	assign pitch = PITCH0 >> oct_i;
	assign mask  = {GRID_LOG2{1'b1}} >> oct_i;
	assign bx    = col_q & mask;
	assign by    = row_q & mask;
	assign x1    = col_q & ~mask;
	assign y1    = row_q & ~mask;
	// The neighbor cell wraps around the grid edge.
	assign x2    = x1 + pitch[GRID_LOG2-1:0];
	assign y2    = y1 + pitch[GRID_LOG2-1:0];
	assign wx    = corner[0] ? {1'b0, bx} : (pitch - {1'b0, bx});
	assign wy    = corner[1] ? {1'b0, by} : (pitch - {1'b0, by});
	assign wprod = wx * wy;
	assign rd_addr = {(corner[1] ? y2 : y1), (corner[0] ? x2 : x1)};

	assign prod_full = rdata_s1 * w_s1;

	// Fold of one octave: divide by the cell area and weight by the octave.
	assign num_sum   = num_q + prod_s2;
	assign oct_rem   = (OCT_W + 1)'(GRID_LOG2) - {1'b0, oct_s2};
	assign shamt     = {oct_rem, 1'b0};
	assign num_shift = num_sum >> shamt;
	assign wsh       = k_last - oct_s2;
	assign acc_add   = ACC_W'(num_shift[SEED_W-1:0]) << wsh;
	assign acc_next  = acc_q + acc_add;
	assign fold_last = v_s2 && last_s2 && (oct_s2 == k_last);

	// Normalization by 2^K - 1, DIV_STEP quotient bits per cycle.
	assign pow_k   = (DIV_W + 1)'(1) << k_q;
	assign divisor = DIV_W'(pow_k - 1'b1);

	always_comb begin : div_step
		logic [DIV_W-1:0]  r;
		logic [DIV_W:0]    t;
		logic [SEED_W-1:0] qn;
		r  = rem_q;
		qn = quo_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			t  = {r, qn[SEED_W-1]};
			qn = {qn[SEED_W-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t     = t - {1'b0, divisor};
				qn[0] = 1'b1;
			end
			r = t[DIV_W-1:0];
		end
		rem_d = r;
		quo_d = qn;
	end

	// The height sum never goes negative: it equals min*(1-n) + max*n.
	assign hdiff    = $signed({1'b0, cfg.max_height}) - $signed({1'b0, cfg.min_height});
	assign hprod    = $signed({1'b0, quo_q}) * hdiff;
	assign hsum     = $signed({2'b00, cfg.min_height, {SEED_W{1'b0}}}) + hprod;
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_q     <= '0;
			iss_on_q  <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			div_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q  <= ST_RUN;
						iss_q    <= '0;
						iss_on_q <= 1'b1;
					end
				end
				ST_RUN: begin
					if (issue) begin
						if (last_iss) begin
							iss_on_q <= 1'b0;
						end else begin
							iss_q <= iss_q + 1'b1;
						end
					end
					if (fold_last) begin
						state_q   <= ST_DIV;
						div_cnt_q <= '0;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[job.addr] <= job.value;
		end
		rdata_s1 <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q   <= k_eff;
			col_q <= job.col;
			row_q <= job.row;
			acc_q <= '0;
			num_q <= '0;
		end
		oct_s1  <= oct_i;
		last_s1 <= &corner;
		w_s1    <= wprod[WGT_W-1:0];
		oct_s2  <= oct_s1;
		last_s2 <= last_s1;
		prod_s2 <= prod_full[NUM_W-1:0];
		if (v_s2) begin
			if (last_s2) begin
				num_q <= '0;
				acc_q <= acc_next;
			end else begin
				num_q <= num_sum;
			end
		end
		if ((state_q == ST_RUN) && fold_last) begin
			rem_q <= acc_next[ACC_W-1:SEED_W];
			quo_q <= acc_next[SEED_W-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
		if (out_load) begin
			noise_q  <= quo_q;
			height_q <= hsum[SEED_W+HEIGHT_W-1:SEED_W];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {height_q, noise_q};

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_RUN) && iss_on_q && (iss_q == '0))
		else $error("query did not start the corner sequence");

	a_div_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (!iss_on_q && !v_s1 && !v_s2))
		else $error("octave pipeline busy during normalization");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result register loaded outside the output state");

endmodule
